// ----- rtl/uidal_pkg.sv -----
// ----------------------------------------------------------------------------
// uidal_pkg
// Shared types and codes for the UID allow-list table: operation and status
// codes, sequencer states, and the control groups passed along the cell row.
// ----------------------------------------------------------------------------
package uidal_pkg;

  // Fixed field widths of the stream payloads
  localparam int OP_W     = 2;
  localparam int UID_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 6;

  // Operation codes carried in the request
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_DUP  = 2'd2,
    STATUS_MISS = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  // Search probe that travels down the row, one cell per cycle
  typedef struct packed {
    logic vld;
    logic hit;
  } probe_t;

  // Broadcast update commands for the cells
  typedef struct packed {
    logic load;   // append the key at slot == count
    logic shift;  // close the gap left by a delete
  } cell_ctrl_t;

endpackage

// ----- rtl/uidal_cell.sv -----
// ----------------------------------------------------------------------------
// uidal_cell
// One table slot: holds a UID, compares it with the passing probe and hands
// the probe on to the next cell. Takes its neighbour's UID on a delete shift.
// ----------------------------------------------------------------------------
module uidal_cell
  import uidal_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 5,
  parameter int CNT_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] count_i,
  input  logic [UID_W-1:0] key_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [IDX_W-1:0] del_pos_i,
  input  logic [UID_W-1:0] next_uid_i,
  output logic [UID_W-1:0] uid_o,
  input  probe_t           probe_i,
  input  logic [IDX_W-1:0] probe_pos_i,
  output probe_t           probe_o,
  output logic [IDX_W-1:0] probe_pos_o
);

  localparam logic [CNT_W-1:0] IdxCnt  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NextCnt = CNT_W'(IDX + 1);
  localparam logic [IDX_W-1:0] IdxPos  = IDX_W'(IDX);

  logic [UID_W-1:0] uid_q, uid_d;
  probe_t           probe_q, probe_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             match;

  // only occupied slots may match
  assign match = (count_i > IdxCnt) && (uid_q == key_i);

  // slot contents: append or pull up from the neighbour
  always_comb begin
    uid_d = uid_q;
    if (ctrl_i.load && (count_i == IdxCnt)) begin
      uid_d = key_i;
    end else if (ctrl_i.shift && (IdxPos >= del_pos_i) && (NextCnt < count_i)) begin
      uid_d = next_uid_i;
    end
  end

  // probe stage: first hit wins
  always_comb begin
    probe_d.vld = probe_i.vld;
    probe_d.hit = probe_i.hit | match;
    pos_d       = probe_i.hit ? probe_pos_i : IdxPos;
  end

  always_ff @(posedge clk_i) begin
    uid_q <= uid_d;
    pos_q <= pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign uid_o       = uid_q;
  assign probe_o     = probe_q;
  assign probe_pos_o = pos_q;

endmodule

// ----- rtl/uid_allow_list_table_core.sv -----
// ----------------------------------------------------------------------------
// uid_allow_list_table_core
// Packed allow-list of card UIDs with add, delete and lookup, built as a row
// of slot cells searched by a probe that moves one cell per cycle.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Contents
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata[1:0] op, tdata[33:2] uid, tdata[39:34] zero
//  m_axis   | out | tdata[1:0] status, tdata[6:2] position,
//           |     | tdata[12:7] user_count, tdata[15:13] zero
//
//  One request at a time; the next request is taken only after the result of
//  the last one has been registered, and the search is paced by the probe
//  walking the cell row one slot per cycle.
//  A delete closes the gap in one update, every later cell pulling up at once.
//  Reset clears the entry count; slot contents need no clearing.
//  A result held on m_axis stalls only the final update, never the walk.
// ----------------------------------------------------------------------------
module uid_allow_list_table_core
  import uidal_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // op[1:0], uid[33:2], zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // status[1:0], position[6:2], user_count[12:7]
);

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);

  state_e           state_q, state_d;
  logic [OP_W-1:0]  op_q;
  logic [UID_W-1:0] key_q;
  logic             start_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             res_hit_q;
  logic [IdxW-1:0]  res_pos_q;

  logic             in_fire, out_free, exec;
  cell_ctrl_t       ctrl;
  status_e          status_d;
  logic [IdxW-1:0]  pos_d;

  logic                 out_vld_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [POS_W-1:0]     out_pos_q;
  logic [COUNT_W-1:0]   out_cnt_q;
  logic [IdxW+POS_W-1:0]   pos_ext;
  logic [CntW+COUNT_W-1:0] cnt_ext;

  probe_t           probe_w     [CAPACITY+1];
  logic [IdxW-1:0]  probe_pos_w [CAPACITY+1];
  logic [UID_W-1:0] uid_w       [CAPACITY];

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= s_axis_tdata_i[OP_W-1:0];
      key_q <= s_axis_tdata_i[OP_W+UID_W-1:OP_W];
    end
  end

  // probe enters the row the cycle after the transfer
  assign probe_w[0].vld = start_q;
  assign probe_w[0].hit = 1'b0;
  assign probe_pos_w[0] = '0;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [UID_W-1:0] next_uid;
    if (i == CAPACITY - 1) begin : g_last
      assign next_uid = uid_w[i];
    end else begin : g_mid
      assign next_uid = uid_w[i+1];
    end

    uidal_cell #(
      .IDX   (i),
      .IDX_W (IdxW),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .count_i     (cnt_q),
      .key_i       (key_q),
      .ctrl_i      (ctrl),
      .del_pos_i   (res_pos_q),
      .next_uid_i  (next_uid),
      .uid_o       (uid_w[i]),
      .probe_i     (probe_w[i]),
      .probe_pos_i (probe_pos_w[i]),
      .probe_o     (probe_w[i+1]),
      .probe_pos_o (probe_pos_w[i+1])
    );
  end

  // search result latch
  always_ff @(posedge clk_i) begin
    if (probe_w[CAPACITY].vld) begin
      res_hit_q <= probe_w[CAPACITY].hit;
      res_pos_q <= probe_pos_w[CAPACITY];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_WALK;
      S_WALK: if (probe_w[CAPACITY].vld) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    exec            = 1'b0;
    case (state_q)
      S_IDLE:  s_axis_tready_o = 1'b1;
      S_WALK:  exec = 1'b0;
      S_DONE:  exec = out_free;
      default: s_axis_tready_o = 1'b0;
    endcase
  end

  // operation decision and table update
  always_comb begin
    status_d   = STATUS_MISS;
    pos_d      = '0;
    cnt_d      = cnt_q;
    ctrl.load  = 1'b0;
    ctrl.shift = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (cnt_q >= CntW'(CAPACITY)) begin
          status_d = STATUS_FULL;
        end else if (res_hit_q) begin
          status_d = STATUS_DUP;
          pos_d    = res_pos_q;
        end else begin
          status_d  = STATUS_OK;
          pos_d     = IdxW'(cnt_q);
          ctrl.load = exec;
          cnt_d     = CntW'(cnt_q + 1'b1);
        end
      end
      OP_DEL: begin
        if (res_hit_q) begin
          status_d   = STATUS_OK;
          pos_d      = res_pos_q;
          ctrl.shift = exec;
          cnt_d      = CntW'(cnt_q - 1'b1);
        end
      end
      OP_LOOKUP: begin
        if (res_hit_q) begin
          status_d = STATUS_OK;
          pos_d    = res_pos_q;
        end
      end
      default: status_d = STATUS_MISS;
    endcase
  end

  // widen or trim to the result field widths
  assign pos_ext = {{POS_W{1'b0}}, pos_d};
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_d};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      start_q   <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_fire;
      if (exec) begin
        cnt_q <= cnt_d;
      end
      if (exec) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_status_q <= status_d;
      out_pos_q    <= pos_ext[POS_W-1:0];
      out_cnt_q    <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_cnt_q, out_pos_q, out_status_q};

endmodule

// ----- verif/uid_allow_list_table_core_test.sv -----
// ----------------------------------------------------------------------------
// uid_allow_list_table_core_test
// Self-checking bench for the UID allow-list table. A short table of directed
// requests (empty table, all-zero and all-one UIDs, duplicates, unused op,
// deletes at the head, middle and tail) is followed by phases of random
// requests that fill the table past capacity, drain it below empty, and mix
// all operations. Each request is predicted by a local copy of the allow-list
// and every result transfer is compared field by field. Both stream sides
// stall at random, with one long calm stretch.
// ----------------------------------------------------------------------------
module uid_allow_list_table_core_test;
  import uidal_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CAPACITY    = 32;
  localparam int          RAND_ITEMS  = 2000;
  localparam int          PHASE_LEN   = 150;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          DIR_N       = 24;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  // One result item
  typedef struct {
    status_e            status;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] count;
  } acl_result_t;

  // One directed row; typed rows carry their expected result
  typedef struct {
    logic [OP_W-1:0]    op;
    logic [UID_W-1:0]   uid;
    bit                 typed;
    status_e            status;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] count;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        s_valid    = 1'b0;
  logic [39:0] s_data     = '0;
  logic        m_ready    = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;

  // Shadow of the allow-list
  logic [UID_W-1:0] acl_uids [CAPACITY];
  int               acl_count;

  acl_result_t      pending_results [$];
  logic [UID_W-1:0] recent_uids [$];
  dir_row_t         dir_rows [DIR_N];
  int               fail_count = 0;
  int               idle_pct   = 37;
  int               quiet_cycles = 0;

  uid_allow_list_table_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Slot of a registered UID, or -1
  function automatic int acl_find(input logic [UID_W-1:0] key);
    for (int i = 0; i < acl_count; i++) begin
      if (acl_uids[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow list and return its result
  function automatic acl_result_t acl_apply(input logic [OP_W-1:0] op,
                                            input logic [UID_W-1:0] key);
    acl_result_t res;
    int          slot;
    res.status = STATUS_MISS;
    res.pos    = '0;
    slot       = acl_find(key);
    if (op == OP_ADD) begin
      if (acl_count >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else if (slot >= 0) begin
        res.status = STATUS_DUP;
        res.pos    = slot[POS_W-1:0];
      end else begin
        acl_uids[acl_count] = key;
        res.pos    = acl_count[POS_W-1:0];
        res.status = STATUS_OK;
        acl_count++;
      end
    end else if (op == OP_DEL) begin
      if (slot >= 0) begin
        for (int j = slot; j + 1 < acl_count; j++) acl_uids[j] = acl_uids[j+1];
        acl_count--;
        res.pos    = slot[POS_W-1:0];
        res.status = STATUS_OK;
      end
    end else if (op == OP_LOOKUP) begin
      if (slot >= 0) begin
        res.pos    = slot[POS_W-1:0];
        res.status = STATUS_OK;
      end
    end
    res.count = acl_count[COUNT_W-1:0];
    return res;
  endfunction

  // UID for a random request: registered, recent, extreme, near miss or fresh
  function automatic logic [UID_W-1:0] pick_uid(input logic [OP_W-1:0] op,
                                                input int phase_kind);
    logic [UID_W-1:0] key;
    int               roll;
    int               hit_pct;
    roll    = $urandom_range(99);
    hit_pct = (op == OP_ADD) ? 15 : ((phase_kind == 1) ? 75 : 50);
    if (acl_count > 0 && roll < hit_pct) begin
      key = acl_uids[$urandom_range(acl_count - 1)];
    end else if (recent_uids.size() > 0 && roll < hit_pct + 12) begin
      key = recent_uids[$urandom_range(recent_uids.size() - 1)];
    end else if (roll < hit_pct + 16) begin
      key = $urandom_range(1) ? '1 : '0;
    end else if (acl_count > 0 && roll < hit_pct + 24) begin
      // differs from a registered UID in one bit only
      key = acl_uids[$urandom_range(acl_count - 1)];
      key[$urandom_range(UID_W - 1)] ^= 1'b1;
    end else begin
      key = $urandom;
      if ($urandom_range(3) == 0) begin
        for (int b = 0; b < UID_W / 8; b++) begin
          if ($urandom_range(1) == 1) key[b*8 +: 8] = 8'h00;
        end
      end
      recent_uids.push_back(key);
      if (recent_uids.size() > 16) void'(recent_uids.pop_front());
    end
    return key;
  endfunction

  // Present one request and hold it until the transfer
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [UID_W-1:0] key,
                               input acl_result_t exp_res);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    pending_results.push_back(exp_res);
    s_valid <= 1'b1;
    s_data  <= {6'd0, key, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Hold the sender off until every pending result has come back
  task automatic hold_until_drained();
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: tdata=%h", m_axis_tdata_o);
        fail_count++;
      end else begin
        acl_result_t exp_res;
        exp_res = pending_results.pop_front();
        if (m_axis_tdata_o[1:0] !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, m_axis_tdata_o[1:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[6:2] !== exp_res.pos) begin
          $error("position: expected %0d, actual %0d", exp_res.pos, m_axis_tdata_o[6:2]);
          fail_count++;
        end
        if (m_axis_tdata_o[12:7] !== exp_res.count) begin
          $error("user_count: expected %0d, actual %0d", exp_res.count,
                 m_axis_tdata_o[12:7]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("uid_allow_list_table_core_test: FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    acl_result_t      exp_res;
    logic [OP_W-1:0]  op;
    logic [UID_W-1:0] key;
    int               phase_kind;
    int               roll;

    dir_rows = '{
      '{OP_LOOKUP, 32'h0000_0000, 1'b1, STATUS_MISS, 5'd0, 6'd0},
      '{OP_DEL,    32'h0000_0000, 1'b1, STATUS_MISS, 5'd0, 6'd0},
      '{OP_ADD,    32'h0000_0000, 1'b1, STATUS_OK,   5'd0, 6'd1},
      '{OP_ADD,    32'hFFFF_FFFF, 1'b1, STATUS_OK,   5'd1, 6'd2},
      '{OP_ADD,    32'h0000_0000, 1'b1, STATUS_DUP,  5'd0, 6'd2},
      '{OP_ADD,    32'hFFFF_FFFF, 1'b1, STATUS_DUP,  5'd1, 6'd2},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, STATUS_OK,   5'd1, 6'd2},
      '{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, STATUS_MISS, 5'd0, 6'd2},
      '{OP_UNUSED, 32'h0000_0000, 1'b1, STATUS_MISS, 5'd0, 6'd2},
      '{OP_LOOKUP, 32'h0000_0001, 1'b1, STATUS_MISS, 5'd0, 6'd2},
      '{OP_LOOKUP, 32'h8000_0000, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_ADD,    32'h00FF_0000, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_ADD,    32'h0000_00FF, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_ADD,    32'h8000_0001, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_ADD,    32'h7FFF_FFFE, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_DEL,    32'h0000_0000, 1'b1, STATUS_OK,   5'd0, 6'd5},
      '{OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_LOOKUP, 32'h7FFF_FFFE, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_DEL,    32'h7FFF_FFFE, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_DEL,    32'h00FF_0000, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_LOOKUP, 32'h0000_00FF, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_DEL,    32'h00FF_0000, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_ADD,    32'h0000_0000, 1'b0, STATUS_OK,   5'd0, 6'd0},
      '{OP_LOOKUP, 32'h0000_0000, 1'b0, STATUS_OK,   5'd0, 6'd0}
    };

    acl_count = 0;
    for (int i = 0; i < CAPACITY; i++) acl_uids[i] = '0;

    // Reset
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests
    foreach (dir_rows[i]) begin
      exp_res = acl_apply(dir_rows[i].op, dir_rows[i].uid);
      if (dir_rows[i].typed) begin
        exp_res.status = dir_rows[i].status;
        exp_res.pos    = dir_rows[i].pos;
        exp_res.count  = dir_rows[i].count;
      end
      issue_request(dir_rows[i].op, dir_rows[i].uid, exp_res);
    end

    // Random phases: fill past capacity, drain past empty, then mixed
    phase_kind = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        hold_until_drained();
        phase_kind = (n / PHASE_LEN) % 3;
      end
      idle_pct = (n >= 1000 && n < 1300) ? 0 : 37;
      roll = $urandom_range(99);
      if (roll < 3) begin
        op = OP_UNUSED;
      end else begin
        case (phase_kind)
          0: op = (roll < 68) ? OP_ADD : ((roll < 88) ? OP_LOOKUP : OP_DEL);
          1: op = (roll < 18) ? OP_ADD : ((roll < 40) ? OP_LOOKUP : OP_DEL);
          default: op = (roll < 40) ? OP_ADD : ((roll < 70) ? OP_LOOKUP : OP_DEL);
        endcase
      end
      key     = pick_uid(op, phase_kind);
      exp_res = acl_apply(op, key);
      issue_request(op, key, exp_res);
    end

    // Wind down
    hold_until_drained();
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("uid_allow_list_table_core_test: PASS");
    end else begin
      $display("uid_allow_list_table_core_test: FAIL");
    end
    $finish;
  end

endmodule
